// File: rtl/assert_macros.svh
// Assertion macros used by the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NORST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

// File: rtl/ridt_pkg.sv
// Types and constants for the request dedup window table.
package ridt_pkg;

  localparam int unsigned TableEntriesDefault = 256;
  localparam logic [31:0] HoldReset = 32'd80000000;
  localparam logic [1:0]  KindWindow = 2'd0;
  localparam logic [1:0]  KindOrphan = 2'd2;
  localparam logic [31:0] OrphanShred = 32'hFFFF_FFFF;
  localparam logic        CmdNeed = 1'b0;
  localparam logic        CmdRemove = 1'b1;

  typedef enum logic [2:0] {
    StSent       = 3'd0,
    StSuppressed = 3'd1,
    StFull       = 3'd2,
    StRemoved    = 3'd3,
    StAbsent     = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    FsmIdle,
    FsmScan,
    FsmDecide
  } fsm_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] slot;
    logic [31:0] shred;
  } key_t;

  typedef struct packed {
    key_t        key;
    logic [62:0] last_send;
  } entry_t;

endpackage

// File: rtl/request_dedup_window_table.sv
// Top level of the request dedup window table.
// Each word (need or remove) is answered by one result word. The table lives
// in one single-port-read, single-port-write memory of TABLE_ENTRIES entries
// with a registered read port; valid bits sit in flip-flops and clear at
// reset. A word scans the whole memory one entry per cycle to find its key and
// the lowest free entry, then the decide state, which waits while the output
// register is stalled, computes the result, writes the entry when it is inserted
// or sent and clears its valid bit on a remove. The linear scan of the memory
// read port sets how long a word takes; the next word is accepted in the cycle
// after the decide state has loaded the output register, even while that result
// still waits to be taken, so a new word is never accepted before the last is done.
`include "assert_macros.svh"
module request_dedup_window_table #(
  parameter int unsigned TABLE_ENTRIES = ridt_pkg::TableEntriesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        command_i,
  input  logic [1:0]  request_kind_i,
  input  logic [63:0] slot_i,
  input  logic [31:0] shred_index_i,
  input  logic [62:0] now_ns_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        send_allowed_o,
  output logic [2:0]  status_o
);
  import ridt_pkg::*;

  localparam int unsigned IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TABLE_ENTRIES - 1);

  // Table memory and valid bits.
  entry_t mem [TABLE_ENTRIES];
  entry_t rd_data_q;
  logic [TABLE_ENTRIES-1:0] vld_q, vld_d;

  logic [31:0] hold_q;

  // Captured word.
  logic        cmd_q;
  key_t        key_q;
  logic [62:0] now_q;

  fsm_e state_q, state_d;

  // Scan control.
  logic [IdxW-1:0] addr_q, addr_d;
  logic            issue_done_q, issue_done_d;
  logic            pend_q, pend_d;
  logic [IdxW-1:0] cmp_idx_q, cmp_idx_d;
  logic            rd_en;

  // Scan findings.
  logic            hit_q, hit_d;
  logic [IdxW-1:0] hit_idx_q, hit_idx_d;
  logic [62:0]     hit_time_q, hit_time_d;
  logic            free_q, free_d;
  logic [IdxW-1:0] free_idx_q, free_idx_d;

  // Decide outputs.
  logic            wr_en;
  logic [IdxW-1:0] wr_idx;
  entry_t          wr_data;
  logic            res_allowed;
  status_e         res_status;
  logic [62:0]     base_time;
  logic [63:0]     due_time;

  logic    out_valid_q, out_valid_d;
  logic    allowed_q;
  status_e status_q;

  logic accept;
  logic load_out;

  assign in_stall_o     = (state_q != FsmIdle);
  assign accept         = in_valid_i && !in_stall_o;
  assign out_valid_o    = out_valid_q;
  assign send_allowed_o = allowed_q;
  assign status_o       = status_q;

  assign base_time = hit_q ? hit_time_q : 63'd0;
  assign due_time  = {1'b0, base_time} + {32'd0, hold_q};

  always_comb begin
    state_d      = state_q;
    addr_d       = addr_q;
    issue_done_d = issue_done_q;
    pend_d       = 1'b0;
    cmp_idx_d    = cmp_idx_q;
    hit_d        = hit_q;
    hit_idx_d    = hit_idx_q;
    hit_time_d   = hit_time_q;
    free_d       = free_q;
    free_idx_d   = free_idx_q;
    vld_d        = vld_q;
    rd_en        = 1'b0;
    wr_en        = 1'b0;
    wr_idx       = hit_idx_q;
    wr_data      = '{key: key_q, last_send: now_q};
    res_allowed  = 1'b0;
    res_status   = StAbsent;
    load_out     = 1'b0;
    out_valid_d  = out_valid_q && out_stall_i;

    unique case (state_q)
      FsmIdle: begin
        if (accept) begin
          state_d      = FsmScan;
          addr_d       = '0;
          issue_done_d = 1'b0;
          hit_d        = 1'b0;
          free_d       = 1'b0;
        end
      end
      FsmScan: begin
        // Issue one read per cycle until the last entry is requested.
        if (!issue_done_q) begin
          rd_en     = 1'b1;
          pend_d    = 1'b1;
          cmp_idx_d = addr_q;
          addr_d    = addr_q + 1'b1;
          if (addr_q == LastIdx) begin
            issue_done_d = 1'b1;
          end
        end
        // Compare the entry read in the previous cycle.
        if (pend_q) begin
          if (vld_q[cmp_idx_q]) begin
            if (!hit_q && rd_data_q.key == key_q) begin
              hit_d      = 1'b1;
              hit_idx_d  = cmp_idx_q;
              hit_time_d = rd_data_q.last_send;
            end
          end else if (!free_q) begin
            free_d     = 1'b1;
            free_idx_d = cmp_idx_q;
          end
          if (cmp_idx_q == LastIdx) begin
            state_d = FsmDecide;
          end
        end
      end
      FsmDecide: begin
        // Hold until the output register can take the result.
        if (!(out_valid_q && out_stall_i)) begin
          load_out    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = FsmIdle;
          if (cmd_q == CmdRemove) begin
            if (hit_q) begin
              vld_d[hit_idx_q] = 1'b0;
              res_status       = StRemoved;
            end else begin
              res_status = StAbsent;
            end
          end else if (!hit_q && !free_q) begin
            res_status = StFull;
          end else begin
            if (!hit_q) begin
              vld_d[free_idx_q] = 1'b1;
              wr_idx            = free_idx_q;
              wr_en             = 1'b1;
            end
            if (due_time < {1'b0, now_q}) begin
              res_allowed = 1'b1;
              res_status  = StSent;
              wr_en       = 1'b1;
            end else begin
              res_status        = StSuppressed;
              wr_data.last_send = 63'd0;
            end
          end
        end
      end
      default: begin
        state_d = FsmIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= mem[addr_q];
    end
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= FsmIdle;
      vld_q        <= '0;
      hold_q       <= HoldReset;
      out_valid_q  <= 1'b0;
      pend_q       <= 1'b0;
      issue_done_q <= 1'b0;
      hit_q        <= 1'b0;
      free_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      vld_q        <= vld_d;
      out_valid_q  <= out_valid_d;
      pend_q       <= pend_d;
      issue_done_q <= issue_done_d;
      hit_q        <= hit_d;
      free_q       <= free_d;
      if (cfg_we_i) begin
        hold_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q     <= addr_d;
    cmp_idx_q  <= cmp_idx_d;
    hit_idx_q  <= hit_idx_d;
    hit_time_q <= hit_time_d;
    free_idx_q <= free_idx_d;
    if (accept) begin
      cmd_q <= command_i;
      now_q <= now_ns_i;
      if (command_i == CmdRemove) begin
        key_q <= '{kind: KindWindow, slot: slot_i, shred: shred_index_i};
      end else if (request_kind_i == KindOrphan) begin
        key_q <= '{kind: request_kind_i, slot: slot_i, shred: OrphanShred};
      end else begin
        key_q <= '{kind: request_kind_i, slot: slot_i, shred: shred_index_i};
      end
    end
    if (load_out) begin
      allowed_q <= res_allowed;
      status_q  <= res_status;
    end
  end

  `ASSERT_CLK(a_wr_only_decide, clk_i, rst_ni, wr_en |-> (state_q == FsmDecide), "write outside decide")
  `ASSERT_CLK(a_allowed_sent, clk_i, rst_ni, (out_valid_q && allowed_q) |-> (status_q == StSent), "allowed not sent")
  `ASSERT_CLK(a_out_from_decide, clk_i, rst_ni, $rose(out_valid_q) |-> ($past(state_q) == FsmDecide), "no decide")
  `ASSERT_CLK(a_scan_one_read, clk_i, rst_ni, (state_q == FsmScan && !issue_done_q) |=> pend_q, "read lost")

endmodule

// File: tb/request_dedup_window_table_tb.sv
// Self-checking testbench for the request dedup window table.
module request_dedup_window_table_tb;
  import ridt_pkg::*;

  localparam int unsigned Depth      = TableEntriesDefault;
  localparam int unsigned SettleCyc  = 300;      // one full scan plus margin
  localparam int unsigned CycleLimit = 3000000;

  // Predictor of the table: lookup, insert at the lowest free entry, hold-window
  // decision, and the queue of result words it expects in order.
  class dedup_scoreboard;
    bit          used [Depth];
    logic [1:0]  key_kind [Depth];
    logic [63:0] key_slot [Depth];
    logic [31:0] key_shred [Depth];
    logic [63:0] last_sent [Depth];
    logic [31:0] hold_ns;
    logic        want_allowed [$];
    status_e     want_status [$];

    function new();
      foreach (used[i]) used[i] = 1'b0;
      hold_ns = HoldReset;
    endfunction

    function int lookup(logic [1:0] kind, logic [63:0] slot, logic [31:0] shred);
      for (int i = 0; i < Depth; i++)
        if (used[i] && key_kind[i] == kind && key_slot[i] == slot && key_shred[i] == shred)
          return i;
      return -1;
    endfunction

    function void note_word(logic cmd, logic [1:0] kind, logic [63:0] slot,
                            logic [31:0] shred, logic [62:0] now);
      int idx;
      logic allowed;
      status_e st;
      allowed = 1'b0;
      if (cmd == CmdRemove) begin
        idx = lookup(KindWindow, slot, shred);
        if (idx >= 0) begin
          used[idx] = 1'b0;
          st = StRemoved;
        end else begin
          st = StAbsent;
        end
      end else begin
        if (kind == KindOrphan) shred = OrphanShred;
        idx = lookup(kind, slot, shred);
        if (idx < 0) begin
          for (int i = 0; i < Depth; i++)
            if (!used[i]) begin
              idx = i;
              break;
            end
          if (idx >= 0) begin
            used[idx] = 1'b1;
            key_kind[idx] = kind;
            key_slot[idx] = slot;
            key_shred[idx] = shred;
            last_sent[idx] = '0;
          end
        end
        if (idx < 0) begin
          st = StFull;
        end else if (last_sent[idx] + {32'd0, hold_ns} < {1'b0, now}) begin
          last_sent[idx] = {1'b0, now};
          allowed = 1'b1;
          st = StSent;
        end else begin
          st = StSuppressed;
        end
      end
      want_allowed.push_back(allowed);
      want_status.push_back(st);
    endfunction

    function int pending();
      return want_status.size();
    endfunction

    // Return 0 when nothing was waiting; fill in the expected fields otherwise.
    function bit check(output logic allowed, output status_e st);
      if (want_status.size() == 0) return 1'b0;
      allowed = want_allowed.pop_front();
      st = want_status.pop_front();
      return 1'b1;
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall_o;
  logic        cmd_r = CmdNeed;
  logic [1:0]  kind_r = KindWindow;
  logic [63:0] slot_r = '0;
  logic [31:0] shred_r = '0;
  logic [62:0] now_r = '0;
  logic        out_valid_o;
  logic        out_stall = 1'b0;
  logic        send_allowed_o;
  logic [2:0]  status_o;

  dedup_scoreboard table_sb = new();
  int          mismatches = 0;
  int unsigned cycles = 0;
  bit          idle_on = 1'b1;
  int          long_hold = 0;
  int          rx_wait = 0;
  logic [62:0] cur_now = '0;
  logic [63:0] slot_pool [6];
  logic [31:0] shred_pool [5];
  logic [63:0] fill_slots [$];
  logic [31:0] fill_shreds [$];

  request_dedup_window_table dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid), .in_stall_o(in_stall_o),
    .command_i(cmd_r), .request_kind_i(kind_r), .slot_i(slot_r),
    .shred_index_i(shred_r), .now_ns_i(now_r),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall),
    .send_allowed_o(send_allowed_o), .status_o(status_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Bound the run; a hang in either handshake lands here.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("request_dedup_window_table_tb NOT OK");
      $finish;
    end
  end

  task automatic report(input string what);
    $display("mismatch at cycle %0d: %s", cycles, what);
    mismatches++;
  endtask

  // Result side: check each accepted word, then pick the stall for next cycle.
  // A long hold takes priority over the per-word random wait.
  always @(posedge clk_i) begin
    logic    exp_allowed;
    status_e exp_status;
    if (rst_ni && out_valid_o && !out_stall) begin
      if (!table_sb.check(exp_allowed, exp_status))
        report("result word with nothing expected");
      else if (send_allowed_o !== exp_allowed || status_o !== exp_status)
        report($sformatf("got allowed %b status %0d, want allowed %b status %0d",
                         send_allowed_o, status_o, exp_allowed, exp_status));
      rx_wait = idle_on ? $urandom_range(0, 6) : 0;
    end
    if (long_hold > 0) begin
      long_hold--;
      out_stall <= 1'b1;
    end else if (rx_wait > 0) begin
      rx_wait--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Offer one word after a random gap (none when idling is off); valid stays high across back-to-back words.
  task automatic send_word(input logic cmd, input logic [1:0] kind, input logic [63:0] slot,
                           input logic [31:0] shred, input logic [62:0] now);
    int gap;
    gap = idle_on ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    cmd_r <= cmd;
    kind_r <= kind;
    slot_r <= slot;
    shred_r <= shred;
    now_r <= now;
    do @(posedge clk_i); while (in_stall_o);
    table_sb.note_word(cmd, kind, slot, shred, now);
  endtask

  // Drop valid, wait for every expected word, then let the scan run out.
  task automatic drain();
    in_valid <= 1'b0;
    while (table_sb.pending() != 0) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  task automatic write_hold(input logic [31:0] value);
    drain();
    cfg_wdata <= value;
    cfg_we <= 1'b1;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    table_sb.hold_ns = value;
  endtask

  // Advance protocol time: mostly steps around the hold window so both
  // suppress and send outcomes show up, sometimes big jumps.
  function automatic logic [62:0] next_now();
    logic [63:0] step;
    logic [63:0] span;
    span = {32'd0, table_sb.hold_ns} * 2 + 2;
    case ($urandom_range(0, 7))
      0: step = '0;
      1: step = {32'd0, table_sb.hold_ns};
      2: step = {24'd0, $urandom, 8'd0};
      default: step = {$urandom, $urandom} % span;
    endcase
    if ({1'b0, cur_now} + step < 64'h7FFF_FFFF_FFFF_FFFF) cur_now = cur_now + step[62:0];
    // now and then offer an unrelated full-range time without keeping it
    if ($urandom_range(0, 19) == 0) return 63'({$urandom, $urandom} >> 1);
    return cur_now;
  endfunction

  // One random word over a small key pool so lookups hit often.
  task automatic random_word();
    logic [31:0] shred;
    shred = ($urandom_range(0, 9) == 0) ? $urandom : shred_pool[$urandom_range(0, 4)];
    send_word(($urandom_range(0, 9) < 3) ? CmdRemove : CmdNeed, 2'($urandom_range(0, 3)),
              slot_pool[$urandom_range(0, 5)], shred, next_now());
  endtask

  // Offer count fresh keys, so the table fills and refuses, then free the window ones.
  task automatic fill_and_free(input int count);
    logic [63:0] slot;
    logic [1:0]  kind;
    for (int i = 0; i < count; i++) begin
      slot = {$urandom, $urandom};
      kind = ($urandom_range(0, 3) == 0) ? 2'($urandom_range(1, 3)) : KindWindow;
      if (kind == KindWindow) begin
        fill_slots.push_back(slot);
        fill_shreds.push_back(32'(i));
      end
      send_word(CmdNeed, kind, slot, 32'(i), next_now());
    end
    while (fill_slots.size() > 0)
      send_word(CmdRemove, 2'($urandom_range(0, 3)), fill_slots.pop_front(),
                fill_shreds.pop_front(), next_now());
  endtask

  initial begin
    slot_pool[0] = '0;
    slot_pool[1] = '1;
    for (int i = 2; i < 6; i++) slot_pool[i] = {$urandom, $urandom};
    shred_pool[0] = '0;
    shred_pool[1] = '1;
    for (int i = 2; i < 5; i++) shred_pool[i] = $urandom;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: boundary of the strict compare, each kind, orphan folding,
    // remove of present and absent keys, extreme fields.
    send_word(CmdNeed, KindWindow, '0, '0, '0);
    send_word(CmdNeed, KindWindow, '0, '0, 63'(HoldReset));
    send_word(CmdNeed, KindWindow, '0, '0, 63'(HoldReset) + 1);
    send_word(CmdNeed, KindWindow, '0, '0, 63'(HoldReset) + 1);
    send_word(CmdNeed, 2'd1, '1, '1, '1);
    send_word(CmdNeed, KindOrphan, 64'd5, 32'd7, '1);
    send_word(CmdNeed, KindOrphan, 64'd5, 32'd0, '1);
    send_word(CmdNeed, 2'd3, 64'd5, 32'd7, '1);
    send_word(CmdNeed, 2'd3, 64'd5, 32'd7, '1);
    send_word(CmdRemove, KindWindow, '0, '0, '0);
    send_word(CmdRemove, 2'd3, '0, '0, '0);
    send_word(CmdRemove, KindWindow, '1, '1, '1);
    send_word(CmdNeed, KindWindow, '0, '0, 63'd100);

    write_hold('0);
    send_word(CmdNeed, KindWindow, 64'd9, 32'd9, 63'd1);
    send_word(CmdNeed, KindWindow, 64'd9, 32'd9, 63'd1);
    send_word(CmdNeed, KindWindow, 64'd9, 32'd9, 63'd2);
    write_hold('1);
    send_word(CmdNeed, 2'd1, 64'd9, 32'd9, '1);
    send_word(CmdNeed, 2'd1, 64'd9, 32'd9, '1);
    send_word(CmdNeed, KindOrphan, '1, '1, 63'h0FFF_FFFF);

    // Random phases over several hold settings; one phase without idling,
    // one opening with a long receiver hold while words keep coming.
    write_hold(HoldReset);
    for (int i = 0; i < 300; i++) random_word();
    write_hold($urandom_range(1, 1000));
    idle_on = 1'b0;
    for (int i = 0; i < 250; i++) random_word();
    idle_on = 1'b1;
    write_hold($urandom);
    long_hold = 3000;
    for (int i = 0; i < 250; i++) random_word();
    write_hold(32'd1000);
    fill_and_free(280);
    for (int i = 0; i < 150; i++) random_word();
    write_hold('0);
    for (int i = 0; i < 200; i++) random_word();

    drain();
    if (mismatches == 0)
      $display("request_dedup_window_table_tb OK");
    else
      $display("request_dedup_window_table_tb NOT OK");
    $finish;
  end

endmodule
